@@ rtl/positional_list_engine_macros.svh @@
// Assertion helpers for the positional_list_engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("positional_list_engine: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("positional_list_engine: next-cycle check failed");

`endif

@@ rtl/ple_pkg.sv @@
`timescale 1ns / 1ps

package ple_pkg;

	// Field widths of the stream words
	localparam int CMD_W = 3;
	localparam int POS_W = 5;
	localparam int VAL_W = 32;
	localparam int CNT_W = 5;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	// Defaults for the top-level parameters
	localparam int DEPTH_DEF = 16;
	localparam int WIDTH_DEF = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT  = 3'd0,
		CMD_REMOVE  = 3'd1,
		CMD_GET     = 3'd2,
		CMD_REPLACE = 3'd3,
		CMD_CLEAR   = 3'd4
	} cmd_t;

endpackage

@@ rtl/ple_mem.sv @@
`timescale 1ns / 1ps

// Entry store: one write port, one read port with registered data.
module ple_mem
	import ple_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WIDTH = WIDTH_DEF,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/positional_list_engine.sv @@
`timescale 1ns / 1ps

// Channel | Dir | Fields (tdata / tuser, low bit first)
// s_*     | in  | tdata: position[4:0], value[36:5], zero pad; tuser: cmd[2:0]
// m_*     | out | tdata: data[31:0], count[36:32], empty_res[37], zero pad; tuser: ok
//
// One word at a time; s_tready is high only while the engine is idle.
// Reject, clear and a remove of the last entry go straight to the result;
// get/replace read the entry first, and an insert at the end writes it.
// Shifting inserts and removes walk the moved entries through the memory's
// read and write ports, one per cycle, before an insert writes its entry.
// Reset clears the list length; entry storage is not cleared.
// A stalled result holds in the output register; the engine waits for it.
module positional_list_engine
	import ple_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // position, value
	input  logic [CMD_W-1:0]     s_tuser,  // cmd
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // data, count, empty_res
	output logic                 m_tuser   // ok
);

`include "positional_list_engine_macros.svh"

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LEN_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_DRAIN,
		ST_PUT,
		ST_READ,
		ST_GRAB,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [LEN_W-1:0]    len_q;
	cmd_t                cmd_q;
	logic [ADDR_W-1:0]   at_q;
	logic [WIDTH-1:0]    val_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [ADDR_W-1:0]   end_q;
	logic                down_q;
	logic                rd_pend_q;
	logic [ADDR_W-1:0]   rd_dst_q;
	logic                ok_q;
	logic [VAL_W-1:0]    res_data_q;
	logic                m_tvalid_q;
	logic                m_ok_q;
	logic [VAL_W-1:0]    m_data_q;
	logic [CNT_W-1:0]    m_count_q;
	logic                m_empty_q;

	logic [POS_W-1:0]    in_pos;
	logic [VAL_W-1:0]    in_val;
	cmd_t                in_cmd;
	logic [CMP_W-1:0]    pos_c;
	logic [CMP_W-1:0]    len_c;
	logic [CMP_W-1:0]    at_c;
	logic                pos_in;
	logic                ins_ok;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [WIDTH-1:0]    mem_wdata;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_raddr;
	logic [WIDTH-1:0]    mem_rdata;

	assign in_pos = s_tdata[POS_W-1:0];
	assign in_val = s_tdata[POS_W +: VAL_W];
	assign in_cmd = cmd_t'(s_tuser);

	assign pos_c  = CMP_W'(in_pos);
	assign len_c  = CMP_W'(len_q);
	assign at_c   = pos_c - CMP_W'(1);
	assign pos_in = (pos_c != '0) && (pos_c <= len_c);
	assign ins_ok = (pos_c != '0) && (pos_c <= len_c + CMP_W'(1)) &&
		(len_c < CMP_W'(DEPTH));

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			len_q      <= '0;
			rd_pend_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_pend_q <= (state_q == ST_SHIFT);
			// ST_DONE drives the output register itself
			if (m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q      <= in_cmd;
						at_q       <= ADDR_W'(at_c);
						val_q      <= WIDTH'(in_val);
						res_data_q <= '0;
						ok_q       <= 1'b0;
						state_q    <= ST_DONE;
						case (in_cmd)
							CMD_INSERT: begin
								if (ins_ok) begin
									ok_q  <= 1'b1;
									len_q <= len_q + LEN_W'(1);
									if (len_c > at_c) begin
										idx_q   <= ADDR_W'(len_c - CMP_W'(1));
										end_q   <= ADDR_W'(at_c);
										down_q  <= 1'b1;
										state_q <= ST_SHIFT;
									end else begin
										state_q <= ST_PUT;
									end
								end
							end
							CMD_REMOVE: begin
								if (pos_in) begin
									ok_q  <= 1'b1;
									len_q <= len_q - LEN_W'(1);
									if (at_c + CMP_W'(1) < len_c) begin
										idx_q   <= ADDR_W'(at_c + CMP_W'(1));
										end_q   <= ADDR_W'(len_c - CMP_W'(1));
										down_q  <= 1'b0;
										state_q <= ST_SHIFT;
									end
								end
							end
							CMD_GET, CMD_REPLACE: begin
								if (pos_in) begin
									ok_q    <= 1'b1;
									state_q <= ST_READ;
								end
							end
							CMD_CLEAR: begin
								ok_q  <= 1'b1;
								len_q <= '0;
							end
							default: begin
								ok_q <= 1'b0;
							end
						endcase
					end
				end
				ST_SHIFT: begin
					// read idx now, its word lands one slot over next cycle
					rd_dst_q <= down_q ? idx_q + ADDR_W'(1) : idx_q - ADDR_W'(1);
					if (idx_q == end_q) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= down_q ? idx_q - ADDR_W'(1) : idx_q + ADDR_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= (cmd_q == CMD_INSERT) ? ST_PUT : ST_DONE;
				end
				ST_PUT: begin
					state_q <= ST_DONE;
				end
				ST_READ: begin
					state_q <= ST_GRAB;
				end
				ST_GRAB: begin
					res_data_q <= VAL_W'(mem_rdata);
					state_q    <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_ok_q     <= ok_q;
						m_data_q   <= res_data_q;
						m_count_q  <= CNT_W'(len_q);
						m_empty_q  <= (len_q == '0);
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Memory port steering: a pending shift word wins the write port.
	always_comb begin
		mem_re    = (state_q == ST_SHIFT) || (state_q == ST_READ);
		mem_raddr = (state_q == ST_SHIFT) ? idx_q : at_q;
		mem_we    = rd_pend_q || (state_q == ST_PUT) ||
			((state_q == ST_GRAB) && (cmd_q == CMD_REPLACE));
		mem_waddr = rd_pend_q ? rd_dst_q : at_q;
		mem_wdata = rd_pend_q ? mem_rdata : val_q;
	end

	ple_mem #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_ok_q;
	assign m_tdata  = {(M_TDATA_W - VAL_W - CNT_W - 1)'(0), m_empty_q, m_count_q, m_data_q};

	`PLE_ASSERT_SAME(a_len_bound, clk, arst_n, 1'b1, LEN_W'(DEPTH) >= len_q)
	`PLE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready,
		state_q != ST_IDLE)
	`PLE_ASSERT_SAME(a_pend_in_shift, clk, arst_n, rd_pend_q,
		(state_q == ST_SHIFT) || (state_q == ST_DRAIN))
	`PLE_ASSERT_SAME(a_waddr_range, clk, arst_n, mem_we,
		ADDR_W'(DEPTH - 1) >= mem_waddr)

endmodule
